@@ hw/rtl/rubi_pkg.sv @@
package rubi_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int TEX_WIDTH   = 17;
	localparam int NRM_WIDTH   = 2;
	localparam int AXIS_WIDTH  = 2;

	localparam logic [AXIS_WIDTH-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_WIDTH-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_WIDTH-1:0] AXIS_Z = 2'd2;

endpackage

@@ hw/rtl/rubi_div.sv @@
// Pipelined signed divider, one quotient bit per stage, truncating towards
// zero and saturating to the signed W-bit range.
module rubi_div #(
	parameter int NW = 40,
	parameter int W  = 32,
	parameter int SH = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [W-1:0]  den,
	output logic signed [W-1:0]  quo
);
	localparam int QW = NW + SH;
	localparam int NS = QW;

	logic [QW-1:0] rem_s [NS+1];
	logic [QW-1:0] quo_s [NS+1];
	logic [W-1:0]  dv_s  [NS+1];
	logic          neg_s [NS+1];
	logic [QW:0]   par_s [NS+1];

	logic [QW-1:0] num_mag;
	assign num_mag = num[NW-1] ? QW'(-{{SH{num[NW-1]}}, num}) << SH
	                           : QW'({{SH{1'b0}}, num}) << SH;

	always_comb begin
		rem_s[0] = num_mag;
		quo_s[0] = '0;
		dv_s[0]  = den[W-1] ? W'(-den) : den;
		neg_s[0] = num[NW-1] ^ den[W-1];
		par_s[0] = '0;
	end

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [QW:0] trial;
		logic [QW:0] pr;
		always_comb begin
			pr    = {par_s[g][QW-1:0], rem_s[g][QW-1]};
			trial = pr - (QW+1)'(dv_s[g]);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= rem_s[g] << 1;
				dv_s[g+1]  <= dv_s[g];
				neg_s[g+1] <= neg_s[g];
				if (!trial[QW]) begin
					par_s[g+1] <= trial;
					quo_s[g+1] <= {quo_s[g][QW-2:0], 1'b1};
				end else begin
					par_s[g+1] <= pr;
					quo_s[g+1] <= {quo_s[g][QW-2:0], 1'b0};
				end
			end
		end
	end

	localparam logic [QW:0] MAXP = (QW+1)'({1'b0, {(W-1){1'b1}}});
	logic [QW:0] qe;
	always_comb begin
		qe = {1'b0, quo_s[NS]};
		if (neg_s[NS]) begin
			if (qe > MAXP + 1) quo = {1'b1, {(W-1){1'b0}}};
			else quo = W'(-qe);
		end else begin
			if (qe > MAXP) quo = {1'b0, {(W-1){1'b1}}};
			else quo = W'(qe);
		end
	end
endmodule

@@ hw/rtl/rubi_lane.sv @@
// One axis: two slab divisions, ordered entry/exit, unbounded and miss flags.
module rubi_lane #(
	parameter int W  = rubi_pkg::COORD_WIDTH,
	parameter int FB = rubi_pkg::FRAC_BITS,
	parameter int LAT = 1
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] o,
	input  logic signed [W-1:0] d,
	output logic signed [W-1:0] t_near,
	output logic signed [W-1:0] t_far,
	output logic                unb,
	output logic                miss
);
	localparam int NW = W + 2;
	logic signed [NW-1:0] na, nb;
	logic signed [W-1:0]  qa, qb;
	logic unb_d [LAT+1];
	logic miss_d [LAT+1];
	localparam logic signed [NW-1:0] ONE = NW'(1) <<< FB;

	assign na = -ONE - NW'(o);
	assign nb =  ONE - NW'(o);

	rubi_div #(.NW(NW), .W(W), .SH(FB)) u_da (.clk, .en, .num(na), .den(d), .quo(qa));
	rubi_div #(.NW(NW), .W(W), .SH(FB)) u_db (.clk, .en, .num(nb), .den(d), .quo(qb));

	always_comb begin
		unb_d[0]  = (d == '0);
		miss_d[0] = (d == '0) && (NW'(o) < -ONE || NW'(o) > ONE);
	end
	for (genvar g = 0; g < LAT; g++) begin : g_dl
		always_ff @(posedge clk) begin
			if (en) begin
				unb_d[g+1]  <= unb_d[g];
				miss_d[g+1] <= miss_d[g];
			end
		end
	end
	assign unb    = unb_d[LAT];
	assign miss   = miss_d[LAT];
	assign t_near = (qa < qb) ? qa : qb;
	assign t_far  = (qa < qb) ? qb : qa;
endmodule

@@ hw/rtl/rubi_merge.sv @@
// Merges the three lanes, then computes normal, hit point and u/v.
module rubi_merge #(
	parameter int W  = rubi_pkg::COORD_WIDTH,
	parameter int FB = rubi_pkg::FRAC_BITS
) (
	input  logic                clk,
	input  logic signed [W-1:0] o   [3],
	input  logic signed [W-1:0] d   [3],
	input  logic signed [W-1:0] tn_l [3],
	input  logic signed [W-1:0] tf_l [3],
	input  logic                unb [3],
	input  logic                miss_l [3],
	input  logic                en,
	output logic [W+2*rubi_pkg::TEX_WIDTH+8:0] res
);
	localparam int TW = rubi_pkg::TEX_WIDTH;
	// stage 1: near/far reduction
	logic signed [W:0] tn, tf;
	logic hit;
	always_comb begin
		tn = {1'b1, {W{1'b0}}};
		tf = {1'b0, {W{1'b1}}};
		for (int i = 0; i < 3; i++) begin
			if (!unb[i] && (W+1)'(tn_l[i]) > tn) tn = (W+1)'(tn_l[i]);
			if (!unb[i] && (W+1)'(tf_l[i]) < tf) tf = (W+1)'(tf_l[i]);
		end
		hit = !(miss_l[0] || miss_l[1] || miss_l[2]) && !(tn > tf) && !tf[W];
	end
	logic signed [W:0] tn_s1;
	logic hit_s1;
	logic signed [1:0] n_s1 [3];
	logic signed [W-1:0] o_s1 [3], d_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			tn_s1  <= tn;
			hit_s1 <= hit;
			for (int i = 0; i < 3; i++) begin
				o_s1[i] <= o[i];
				d_s1[i] <= d[i];
				if (!unb[i] && (W+1)'(tn_l[i]) == tn) begin
					if (d[i] == '0) n_s1[i] <= 2'sd0;
					else if (d[i][W-1] ^ tn[W]) n_s1[i] <= 2'sd1;
					else n_s1[i] <= -2'sd1;
				end else n_s1[i] <= 2'sd0;
			end
		end
	end
	// stage 2: multiply; the all-unbounded marker below the word range maps
	// to the most negative distance.
	logic signed [W-1:0] tc;
	assign tc = (tn_s1[W] != tn_s1[W-1]) ? {1'b1, {(W-1){1'b0}}} : tn_s1[W-1:0];
	logic signed [2*W-1:0] m_s2 [3];
	logic signed [W-1:0] o_s2 [3], tc_s2;
	logic hit_s2;
	logic signed [1:0] n_s2 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			tc_s2 <= tc;
			hit_s2 <= hit_s1;
			for (int i = 0; i < 3; i++) begin
				m_s2[i] <= d_s1[i] * tc;
				o_s2[i] <= o_s1[i];
				n_s2[i] <= n_s1[i];
			end
		end
	end
	// stage 3: hit point, tex and output
	logic [TW-1:0] h [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [2*W:0] p, hh;
			p  = (2*W+1)'(o_s2[i]) + (2*W+1)'(m_s2[i] >>> FB);
			hh = (p >>> 1) + (2*W+1)'(1 <<< (FB-1));
			if (hh[2*W]) h[i] = '0;
			else if (hh > (2*W+1)'(1 <<< FB)) h[i] = TW'(1 <<< FB);
			else h[i] = TW'(hh);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (!hit_s2) res <= '0;
			else if (n_s2[0] != 0)
				res <= {rubi_pkg::AXIS_Z, h[2], h[1], n_s2[2], n_s2[1], n_s2[0], tc_s2, 1'b1};
			else if (n_s2[1] != 0)
				res <= {rubi_pkg::AXIS_X, h[2], h[0], n_s2[2], n_s2[1], n_s2[0], tc_s2, 1'b1};
			else
				res <= {rubi_pkg::AXIS_Y, h[1], h[0], n_s2[2], n_s2[1], n_s2[0], tc_s2, 1'b1};
		end
	end
endmodule

@@ hw/rtl/ray_unit_box_intersect_top.sv @@
// Ray against the cube [-1,1]^3 in signed Q16.16. One item enters per
// cycle while the pipeline advances; three axis lanes each run two pipelined
// restoring dividers of COORD_WIDTH+FRAC_BITS+2 stages, then three merge
// stages follow. The pipeline only advances when the output can move, which
// is the only source of stalls.
module ray_unit_box_intersect_top #(
	parameter int COORD_WIDTH = rubi_pkg::COORD_WIDTH,
	parameter int FRAC_BITS   = rubi_pkg::FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [6*COORD_WIDTH-1:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// hit_found, hit_distance, normal_x/y/z, tex_u, tex_v, tangent_axis, pad
	output logic [((COORD_WIDTH+2*rubi_pkg::TEX_WIDTH+9+7)/8)*8-1:0] m_tdata
);
	localparam int W = COORD_WIDTH;
	localparam int LAT = W + 2 + FRAC_BITS;
	localparam int TOT = LAT + 3;
	localparam int RW = W + 2*rubi_pkg::TEX_WIDTH + 9;
	localparam int TDW = $bits(m_tdata);

	// Every stage, the valid shift line included, moves on one common
	// enable. It is high whenever the output register is empty or is being
	// emptied, so a result that waits holds the whole pipeline and the input.
	logic signed [W-1:0] o [3], d [3], tn [3], tf [3];
	logic unb [3], ms [3];
	logic [RW-1:0] res;
	logic [TOT-1:0] vld_q;
	logic en;

	assign en = !m_tvalid || m_tready;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		assign o[i] = s_tdata[i*W +: W];
		assign d[i] = s_tdata[(3+i)*W +: W];
		rubi_lane #(.W(W), .FB(FRAC_BITS), .LAT(LAT)) u_lane (
			.clk, .en, .o(o[i]), .d(d[i]),
			.t_near(tn[i]), .t_far(tf[i]), .unb(unb[i]), .miss(ms[i]));
	end

	logic signed [W-1:0] od [LAT+1][3], dd [LAT+1][3];
	assign od[0] = o;
	assign dd[0] = d;
	for (genvar g = 0; g < LAT; g++) begin : g_dl
		always_ff @(posedge clk) begin
			if (en) begin
				od[g+1] <= od[g];
				dd[g+1] <= dd[g];
			end
		end
	end

	rubi_merge #(.W(W), .FB(FRAC_BITS)) u_merge (
		.clk, .o(od[LAT]), .d(dd[LAT]), .tn_l(tn), .tf_l(tf), .unb, .miss_l(ms),
		.en, .res);

	assign s_tready = en;
	assign m_tvalid = vld_q[TOT-1];
	assign m_tdata = {{(TDW-RW){1'b0}}, res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOT-2:0], s_tvalid};
		end
	end
endmodule

@@ tb/sv/ray_box_hit_checker.sv @@
// Watches both streams of the ray/cube intersection block, predicts every
// result from the accepted ray and compares it field by field.
module ray_box_hit_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [191:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [79:0]  m_tdata,
	output int           errors,
	output int           pending,
	output int           hits_seen,
	output int           results_seen
);
	typedef struct packed {
		logic                            hit;
		logic [31:0]                     distance;
		logic [rubi_pkg::NRM_WIDTH-1:0]  nx;
		logic [rubi_pkg::NRM_WIDTH-1:0]  ny;
		logic [rubi_pkg::NRM_WIDTH-1:0]  nz;
		logic [rubi_pkg::TEX_WIDTH-1:0]  u;
		logic [rubi_pkg::TEX_WIDTH-1:0]  v;
		logic [rubi_pkg::AXIS_WIDTH-1:0] tangent;
	} hit_t;

	localparam longint ONE_FX  = longint'(1) << rubi_pkg::FRAC_BITS;
	localparam longint HALF_FX = longint'(1) << (rubi_pkg::FRAC_BITS - 1);
	localparam longint T_MAX   = (longint'(1) << (rubi_pkg::COORD_WIDTH - 1)) - 1;
	localparam longint T_MIN   = -T_MAX - 1;
	localparam longint UNB_HI  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint UNB_LO  = -UNB_HI - 1;

	hit_t expected_hits[$];

	function automatic longint clamp_t(longint x);
		if (x > T_MAX) return T_MAX;
		if (x < T_MIN) return T_MIN;
		return x;
	endfunction

	function automatic logic [rubi_pkg::TEX_WIDTH-1:0] surface_coord(longint p);
		longint h;
		h = (p >>> 1) + HALF_FX;
		if (h < 0) h = 0;
		if (h > ONE_FX) h = ONE_FX;
		return h[rubi_pkg::TEX_WIDTH-1:0];
	endfunction

	function automatic int sign_of(longint x);
		return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
	endfunction

	function automatic hit_t predict_hit(logic [191:0] ray);
		longint o[3], d[3], lo[3], p[3];
		longint tn, tf, a, b, hi;
		logic [rubi_pkg::TEX_WIDTH-1:0] h[3];
		int nrm[3];
		int s;
		bit miss;
		hit_t r;
		r = '0;
		tn = UNB_LO;
		tf = UNB_HI;
		miss = 0;
		for (int i = 0; i < 3; i++) begin
			o[i] = $signed(ray[32*i +: 32]);
			d[i] = $signed(ray[32*(i+3) +: 32]);
		end
		for (int i = 0; i < 3; i++) begin
			if (d[i] == 0) begin
				// A still axis bounds nothing if the origin is inside its slab.
				if (o[i] < -ONE_FX || o[i] > ONE_FX) miss = 1;
				lo[i] = UNB_LO;
				hi = UNB_HI;
			end else begin
				a = clamp_t(((-ONE_FX - o[i]) * ONE_FX) / d[i]);
				b = clamp_t(((ONE_FX - o[i]) * ONE_FX) / d[i]);
				lo[i] = (a < b) ? a : b;
				hi = (a < b) ? b : a;
			end
			if (lo[i] > tn) tn = lo[i];
			if (hi < tf) tf = hi;
		end
		if (miss || tn > tf || tf < 0) return r;
		for (int i = 0; i < 3; i++) begin
			s = (tn >= 0) ? -sign_of(d[i]) : sign_of(d[i]);
			nrm[i] = (lo[i] == tn) ? s : 0;
		end
		if (tn == UNB_LO) tn = T_MIN;
		for (int i = 0; i < 3; i++) begin
			p[i] = o[i] + ((d[i] * tn) >>> rubi_pkg::FRAC_BITS);
			h[i] = surface_coord(p[i]);
		end
		r.hit = 1'b1;
		r.distance = tn[31:0];
		r.nx = nrm[0][1:0];
		r.ny = nrm[1][1:0];
		r.nz = nrm[2][1:0];
		if (nrm[0] != 0) begin
			r.u = h[1]; r.v = h[2]; r.tangent = rubi_pkg::AXIS_Z;
		end else if (nrm[1] != 0) begin
			r.u = h[0]; r.v = h[2]; r.tangent = rubi_pkg::AXIS_X;
		end else begin
			r.u = h[0]; r.v = h[1]; r.tangent = rubi_pkg::AXIS_Y;
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("result %0d: %s is %h, expected %h", results_seen, field, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		hit_t got, want;
		if (!arst_n) begin
			errors = 0;
			hits_seen = 0;
			results_seen = 0;
			expected_hits.delete();
		end else begin
			if (s_tvalid && s_tready) expected_hits.push_back(predict_hit(s_tdata));
			if (m_tvalid && m_tready) begin
				got.hit      = m_tdata[0];
				got.distance = m_tdata[32:1];
				got.nx       = m_tdata[34:33];
				got.ny       = m_tdata[36:35];
				got.nz       = m_tdata[38:37];
				got.u        = m_tdata[55:39];
				got.v        = m_tdata[72:56];
				got.tangent  = m_tdata[74:73];
				if (expected_hits.size() == 0) begin
					$display("result %0d arrived with nothing expected", results_seen);
					errors++;
				end else begin
					want = expected_hits.pop_front();
					if (got.hit != want.hit)
						report_mismatch("hit_found", 32'(got.hit), 32'(want.hit));
					if (got.distance != want.distance)
						report_mismatch("hit_distance", got.distance, want.distance);
					if (got.nx != want.nx)
						report_mismatch("normal_x", 32'(got.nx), 32'(want.nx));
					if (got.ny != want.ny)
						report_mismatch("normal_y", 32'(got.ny), 32'(want.ny));
					if (got.nz != want.nz)
						report_mismatch("normal_z", 32'(got.nz), 32'(want.nz));
					if (got.u != want.u) report_mismatch("tex_u", 32'(got.u), 32'(want.u));
					if (got.v != want.v) report_mismatch("tex_v", 32'(got.v), 32'(want.v));
					if (got.tangent != want.tangent)
						report_mismatch("tangent_axis", 32'(got.tangent), 32'(want.tangent));
					if (want.hit) hits_seen++;
				end
				results_seen++;
			end
		end
		pending = expected_hits.size();
	end

endmodule

@@ tb/sv/ray_unit_box_intersect_top_tb.sv @@
// Stimulus and verdict for the ray/cube intersection block. The checker
// beside the block predicts and compares; this module only feeds rays,
// throttles the result side and decides the outcome.
module ray_unit_box_intersect_top_tb;
	// One unit in Q16.16.
	localparam int ONE_Q = 1 << rubi_pkg::FRAC_BITS;
	// Idle cycles with no item moving on either side before the run is given up.
	localparam int WATCHDOG_LIMIT = 4000;
	// Pipeline depth: one divider pass plus the merge stages, with margin.
	localparam int DRAIN_CYCLES = 80;
	localparam int ITEMS_PER_PHASE = 235;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [191:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [79:0]  m_tdata;

	int errors, pending, hits_seen, results_seen;
	int idle_pct = 0;
	int stall_pct = 0;
	int rays_sent = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	ray_unit_box_intersect_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	ray_box_hit_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending),
		.hits_seen(hits_seen), .results_seen(results_seen)
	);

	// The result side is throttled at the falling edge so that ready is
	// stable when the block looks at it on the next rising edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// A cycle in which neither side completes an item counts towards the
	// watchdog; any completed item resets it.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout with %0d results outstanding", pending);
				$display("Mismatches found");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic logic [191:0] make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
		return {dz, dy, dx, oz, oy, ox};
	endfunction

	// Presents one ray at the falling edge, inserting random idle cycles
	// first, and holds it until the block takes it. Valid is left high so
	// back-to-back items run without a gap.
	task automatic send_ray(logic [191:0] ray);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ray;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		rays_sent++;
		@(negedge clk);
	endtask

	// Most random rays are aimed at a point inside the cube from a nearby
	// origin, so that hits on every face, corner ties and inside starts are
	// common. The rest have a still axis, whole-unit values, tiny directions
	// or raw noise, which also toggles every bit of the input word.
	function automatic logic [191:0] random_ray();
		int o[3], d[3];
		int pick;
		pick = $urandom_range(99);
		for (int i = 0; i < 3; i++) begin
			o[i] = int'($urandom_range(6*ONE_Q)) - 3*ONE_Q;
			d[i] = int'($urandom_range(2*ONE_Q)) - ONE_Q - o[i];
		end
		if (pick < 15) begin
			d[$urandom_range(2)] = 0;
		end else if (pick < 22) begin
			// Snap components to whole units so that exact ties between slabs occur.
			for (int i = 0; i < 3; i++) begin
				o[i] = (int'($urandom_range(6)) - 3) * ONE_Q;
				d[i] = (int'($urandom_range(4)) - 2) * ONE_Q;
			end
		end else if (pick < 30) begin
			// Tiny directions push the divider into saturation.
			for (int i = 0; i < 3; i++) d[i] = int'($urandom_range(64)) - 32;
		end else if (pick < 42) begin
			for (int i = 0; i < 3; i++) begin
				o[i] = $urandom;
				d[i] = $urandom;
			end
		end
		return make_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
	endfunction

	task automatic run_directed();
		int big, low;
		big = 32'h7FFF_FFFF;
		low = 32'h8000_0000;
		// Hits on each face from both sides, the last one oblique.
		send_ray(make_ray(-3*ONE_Q, 0, 0, ONE_Q, 0, 0));
		send_ray(make_ray(3*ONE_Q, 0, 0, -ONE_Q, 0, 0));
		send_ray(make_ray(0, -3*ONE_Q, 0, 0, ONE_Q, 0));
		send_ray(make_ray(0, 3*ONE_Q, 0, 0, -ONE_Q, 0));
		send_ray(make_ray(0, 0, -3*ONE_Q, 0, 0, ONE_Q));
		send_ray(make_ray(ONE_Q/3, ONE_Q/5, 3*ONE_Q, ONE_Q/7, 0, -2*ONE_Q));
		// Origin inside the cube gives a negative entry distance.
		send_ray(make_ray(ONE_Q/4, -ONE_Q/2, ONE_Q/8, ONE_Q, ONE_Q/3, -ONE_Q/5));
		// Cube behind the ray.
		send_ray(make_ray(3*ONE_Q, 0, 0, ONE_Q, 0, 0));
		// Entry after exit.
		send_ray(make_ray(-3*ONE_Q, 3*ONE_Q, 0, ONE_Q, ONE_Q, 0));
		// Corner hit: all three entries tie; then an edge hit where two tie.
		send_ray(make_ray(-2*ONE_Q, -2*ONE_Q, -2*ONE_Q, ONE_Q, ONE_Q, ONE_Q));
		send_ray(make_ray(2*ONE_Q, -2*ONE_Q, 0, -ONE_Q, ONE_Q, 0));
		// Still axes: origin on the slab edge and just outside.
		send_ray(make_ray(ONE_Q, -ONE_Q, -3*ONE_Q, 0, 0, ONE_Q));
		send_ray(make_ray(ONE_Q + 1, 0, -3*ONE_Q, 0, 0, ONE_Q));
		send_ray(make_ray(0, -ONE_Q - 1, -3*ONE_Q, 0, 0, ONE_Q));
		// Every axis still with the origin inside, and outside.
		send_ray(make_ray(ONE_Q/2, -ONE_Q, ONE_Q/3, 0, 0, 0));
		send_ray(make_ray(0, 0, 0, 0, 0, 0));
		send_ray(make_ray(0, 0, 2*ONE_Q, 0, 0, 0));
		// Extremes of the fields and divider saturation.
		send_ray(make_ray(low, low, low, big, big, big));
		send_ray(make_ray(big, big, big, low, low, low));
		send_ray(make_ray(0, 0, 0, 1, -1, 1));
		send_ray(make_ray(-3*ONE_Q, 0, 0, 1, 0, 0));
		send_ray(make_ray(low, 0, 0, big, 0, 0));
		send_ray(make_ray(-1, -1, -1, -1, -1, -1));
		send_ray(make_ray(big, low, 0, -1, 1, 1));
	endtask

	initial begin
		int idle_set[4] = '{0, 80, 0, 19};
		int stall_set[4] = '{0, 0, 80, 19};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_set[ph];
			stall_pct = stall_set[ph];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) send_ray(random_ray());
		end
		s_tvalid <= 1'b0;

		// Wait for the last results to drain, then give the pipeline a
		// little longer in case anything unexpected follows.
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d rays under four idle and stall patterns; %0d results checked.",
			rays_sent, results_seen);
		$display("Of those, %0d were hits covering faces, corners and still axes.", hits_seen);
		if (errors == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ ray_unit_box_intersect_top.f @@
hw/rtl/rubi_pkg.sv
hw/rtl/rubi_div.sv
hw/rtl/rubi_lane.sv
hw/rtl/rubi_merge.sv
hw/rtl/ray_unit_box_intersect_top.sv
tb/sv/ray_box_hit_checker.sv
tb/sv/ray_unit_box_intersect_top_tb.sv
